// ===== src/tbc_pkg.sv =====
// Shared types and constants for the top-two blob target combiner.
`default_nettype none

package tbc_pkg;

	localparam int unsigned NCELLS = 2;
	localparam int unsigned COORD_W = 9;
	localparam int unsigned AREA_W = 18;
	localparam int unsigned SIG_W = 3;
	localparam int unsigned CENTER_W = 10;
	localparam int unsigned TWIDTH_W = 12;
	localparam int unsigned SEEN_W = 2;

	localparam logic [SEEN_W-1:0] SEEN_MAX = 2'd2;
	localparam logic [SIG_W-1:0] TARGET_RESET = 3'd1;
	localparam logic signed [CENTER_W-1:0] CENTER_NONE = -10'sd1;
	localparam logic signed [TWIDTH_W-1:0] TWIDTH_NONE = -12'sd1;

	typedef struct packed {
		logic [COORD_W-1:0] block_x;
		logic [COORD_W-1:0] block_width;
		logic [COORD_W-1:0] block_height;
		logic [SIG_W-1:0]   block_signature;
		logic               last_in_frame;
		logic               empty_frame;
	} blob_t;

	typedef struct packed {
		logic signed [CENTER_W-1:0] center_coord;
		logic signed [TWIDTH_W-1:0] target_width;
	} result_t;

	typedef struct packed {
		logic               valid;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] width;
		logic [AREA_W-1:0]  area;
	} entry_t;

	typedef struct packed {
		logic                     last;
		logic                     empty;
		logic                     forced;
		entry_t                   cand;
		entry_t [NCELLS-1:0]      snap;
	} token_t;

endpackage

`default_nettype wire

// ===== src/tbc_front.sv =====
// Input stage: target register, per-frame blob count, signature filter and area multiply.
`default_nettype none

module tbc_front (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [tbc_pkg::SIG_W-1:0] cfg_data,
	input  wire logic                   blob_valid,
	output logic                        blob_ready,
	input  wire tbc_pkg::blob_t         blob,
	output logic                        tok_valid,
	output tbc_pkg::token_t             tok,
	input  wire logic                   tok_ready
);
	import tbc_pkg::*;

	logic [SIG_W-1:0]  target_q;
	logic [SEEN_W-1:0] seen_q;
	logic              vld_s1;
	token_t            tok_s1;
	logic              accept;
	logic              take;
	logic [AREA_W-1:0] area;
	token_t            tok_d;

	assign cfg_ready  = 1'b1;
	assign blob_ready = !vld_s1 || tok_ready;
	assign accept     = blob_valid && blob_ready;

	// The first two blobs of a frame are taken whatever their signature.
	assign take = (seen_q != SEEN_MAX) || (blob.block_signature == target_q);
	assign area = {{(AREA_W-COORD_W){1'b0}}, blob.block_width}
		* {{(AREA_W-COORD_W){1'b0}}, blob.block_height};

	always_comb begin
		tok_d            = '0;
		tok_d.last       = blob.last_in_frame;
		tok_d.empty      = blob.empty_frame;
		tok_d.forced     = 1'b0;
		tok_d.cand.valid = take && !blob.empty_frame;
		tok_d.cand.x     = blob.block_x;
		tok_d.cand.width = blob.block_width;
		tok_d.cand.area  = area;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RESET;
			seen_q   <= '0;
			vld_s1   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				target_q <= cfg_data;
			end
			if (accept) begin
				if (blob.empty_frame || blob.last_in_frame) begin
					seen_q <= '0;
				end else if (seen_q != SEEN_MAX) begin
					seen_q <= seen_q + SEEN_W'(1);
				end
				vld_s1 <= 1'b1;
			end else if (tok_ready) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tok_s1 <= tok_d;
		end
	end

	assign tok_valid = vld_s1;
	assign tok       = tok_s1;

endmodule

`default_nettype wire

// ===== src/tbc_cell.sv =====
// One rank cell of the top-two chain: keeps one blob and passes the smaller one on.
`default_nettype none

module tbc_cell #(
	parameter int unsigned IDX = 0
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire tbc_pkg::token_t in_tok,
	output logic                 out_valid,
	output tbc_pkg::token_t      out_tok,
	input  wire logic            out_ready
);
	import tbc_pkg::*;

	entry_t entry_q;
	logic   vld_s1;
	token_t pass_s1;
	logic   fire;
	logic   win;
	entry_t kept;
	token_t nxt;

	assign in_ready = !vld_s1 || out_ready;
	assign fire     = in_valid && in_ready;

	always_comb begin
		// A blob displaced from the rank above lands here even on an equal area.
		win = in_tok.cand.valid
			&& (!entry_q.valid || in_tok.forced || (in_tok.cand.area > entry_q.area));
		kept = win ? in_tok.cand : entry_q;
		nxt  = in_tok;
		if (win) begin
			nxt.cand   = entry_q;
			nxt.forced = entry_q.valid;
		end else begin
			nxt.forced = 1'b0;
		end
		// At frame end this cell's final blob rides along with the transaction.
		if (in_tok.last && !in_tok.empty) begin
			nxt.snap[IDX] = kept;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
			vld_s1  <= 1'b0;
		end else begin
			if (fire) begin
				if (in_tok.empty || in_tok.last) begin
					entry_q.valid <= 1'b0;
				end else begin
					entry_q <= kept;
				end
				vld_s1 <= 1'b1;
			end else if (out_ready) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			pass_s1 <= nxt;
		end
	end

	assign out_valid = vld_s1;
	assign out_tok   = pass_s1;

endmodule

`default_nettype wire

// ===== src/tbc_final.sv =====
// Frame-end combine: centre and width from the two ranks, held result and output register.
`default_nettype none

module tbc_final (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire tbc_pkg::token_t in_tok,
	output logic                 result_valid,
	output tbc_pkg::result_t     result,
	input  wire logic            result_ready
);
	import tbc_pkg::*;

	result_t             held_q;
	result_t             out_q;
	logic                out_vld_q;
	logic                has_result;
	logic                fire;
	entry_t              best;
	entry_t              second;
	logic [COORD_W-1:0]  x_gap;
	logic [COORD_W:0]    xsum;
	result_t             fresh;

	assign has_result = in_tok.last || in_tok.empty;
	assign in_ready   = !has_result || !out_vld_q || result_ready;
	assign fire       = in_valid && in_ready;

	always_comb begin
		best   = in_tok.snap[0];
		second = in_tok.snap[1];
		x_gap  = (best.x > second.x) ? (best.x - second.x) : (second.x - best.x);
		xsum   = {1'b0, best.x} + {1'b0, second.x};
		if (second.valid) begin
			fresh.center_coord = CENTER_W'(xsum >> 1);
			fresh.target_width = TWIDTH_W'(best.width) + TWIDTH_W'(second.width)
				+ TWIDTH_W'(x_gap);
		end else begin
			fresh.center_coord = CENTER_W'(best.x);
			fresh.target_width = TWIDTH_W'(best.width);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q.center_coord <= CENTER_NONE;
			held_q.target_width <= TWIDTH_NONE;
			out_vld_q           <= 1'b0;
		end else begin
			if (fire && has_result) begin
				if (!in_tok.empty) begin
					held_q <= fresh;
				end
				out_vld_q <= 1'b1;
			end else if (result_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && has_result) begin
			out_q <= in_tok.empty ? held_q : fresh;
		end
	end

	assign result_valid = out_vld_q;
	assign result       = out_q;

endmodule

`default_nettype wire

// ===== src/top_two_blob_target_combiner.sv =====
// Top level: input stage, a chain of two rank cells and the frame-end combine stage.
// Path: from the edge that accepts its last blob, a frame's result is registered in turn
// in the input register, each rank cell and the output register.
// Throughput: one blob per cycle; stages advance independently, so blobs keep
// flowing while a result waits, until the pipeline fills.
// Reset (arst_n low): ranks empty, target signature 1, held result -1 / -1.
`default_nettype none

module top_two_blob_target_combiner (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [tbc_pkg::SIG_W-1:0] cfg_data,
	input  wire logic                      blob_valid,
	output logic                           blob_ready,
	input  wire tbc_pkg::blob_t            blob,
	output logic                           result_valid,
	output tbc_pkg::result_t               result,
	input  wire logic                      result_ready
);
	import tbc_pkg::*;

	logic   chain_valid [NCELLS+1];
	logic   chain_ready [NCELLS+1];
	token_t chain_tok   [NCELLS+1];

	tbc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.blob_valid (blob_valid),
		.blob_ready (blob_ready),
		.blob       (blob),
		.tok_valid  (chain_valid[0]),
		.tok        (chain_tok[0]),
		.tok_ready  (chain_ready[0])
	);

	for (genvar i = 0; i < NCELLS; i++) begin : g_cell
		tbc_cell #(
			.IDX (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[i]),
			.in_ready  (chain_ready[i]),
			.in_tok    (chain_tok[i]),
			.out_valid (chain_valid[i+1]),
			.out_tok   (chain_tok[i+1]),
			.out_ready (chain_ready[i+1])
		);
	end

	tbc_final u_final (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (chain_valid[NCELLS]),
		.in_ready     (chain_ready[NCELLS]),
		.in_tok       (chain_tok[NCELLS]),
		.result_valid (result_valid),
		.result       (result),
		.result_ready (result_ready)
	);

endmodule

`default_nettype wire

// ===== src/tbc_checker.sv =====
// Port-level checks for the top-two blob target combiner, bound to the top level.
`default_nettype none

module tbc_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      result_valid,
	input wire tbc_pkg::result_t          result,
	input wire logic                      result_ready
);
	import tbc_pkg::*;

	localparam logic signed [TWIDTH_W-1:0] TWIDTH_MAX = 12'sd1533;

	// A stalled result transaction holds its value.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// A centre is a pixel coordinate or the never-seen mark.
	a_center_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.center_coord >= CENTER_NONE)
		else $error("center_coord out of range");

	// The combined width never exceeds two widths plus the widest x distance.
	a_width_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.target_width >= TWIDTH_NONE)
			&& (result.target_width <= TWIDTH_MAX))
		else $error("target_width out of range");

	// Both fields carry the never-seen mark together or not at all.
	a_none_paired: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |->
			((result.center_coord == CENTER_NONE) == (result.target_width == TWIDTH_NONE)))
		else $error("never-seen mark on one field only");

endmodule

bind top_two_blob_target_combiner tbc_checker u_tbc_checker (.*);

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the top-two blob target combiner.

module tb;
	import tbc_pkg::*;

	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_ITEMS = 300;
	localparam int BURST_FRAMES = 80;
	localparam int LONG_HOLD = 300;
	localparam longint TIMEOUT_NS = 10_000_000;

	// Tracks the two largest blobs of the current frame and the frame results still owed.
	class target_scoreboard;
		logic [SIG_W-1:0]   target;
		logic [SEEN_W-1:0]  seen;
		logic [COORD_W-1:0] best_x, best_w, sec_x, sec_w;
		logic [AREA_W-1:0]  best_a, sec_a;
		result_t            held;
		result_t            expected_targets[$];
		int                 mismatches;
		int                 blob_count;
		int                 result_count;

		function new();
			target = TARGET_RESET;
			seen = '0;
			best_x = '0;
			best_w = '0;
			sec_x = '0;
			sec_w = '0;
			best_a = '0;
			sec_a = '0;
			held.center_coord = CENTER_NONE;
			held.target_width = TWIDTH_NONE;
			mismatches = 0;
			blob_count = 0;
			result_count = 0;
		endfunction

		function void note_blob(blob_t b);
			logic [AREA_W-1:0]   area;
			logic [COORD_W-1:0]  x_gap;
			logic [CENTER_W-1:0] x_sum;
			logic [TWIDTH_W-1:0] w_sum;
			area = AREA_W'(b.block_width) * AREA_W'(b.block_height);
			blob_count++;
			// An empty frame throws away any partial frame and repeats the held result.
			if (b.empty_frame) begin
				seen = '0;
				expected_targets.push_back(held);
				return;
			end
			if (seen == 0) begin
				best_x = b.block_x;
				best_w = b.block_width;
				best_a = area;
				seen = SEEN_W'(1);
			end else if (seen == 1 || b.block_signature == target) begin
				if (area > best_a) begin
					sec_x = best_x;
					sec_w = best_w;
					sec_a = best_a;
					best_x = b.block_x;
					best_w = b.block_width;
					best_a = area;
				end else if (seen == 1 || area > sec_a) begin
					// A second blob of a frame that is not larger than the best always fills the second slot.
					sec_x = b.block_x;
					sec_w = b.block_width;
					sec_a = area;
				end
				seen = SEEN_MAX;
			end
			if (!b.last_in_frame)
				return;
			if (seen == 1) begin
				held.center_coord = {1'b0, best_x};
				held.target_width = {3'b000, best_w};
			end else begin
				x_gap = (best_x > sec_x) ? best_x - sec_x : sec_x - best_x;
				x_sum = CENTER_W'(best_x) + CENTER_W'(sec_x);
				w_sum = TWIDTH_W'(best_w) + TWIDTH_W'(sec_w) + TWIDTH_W'(x_gap);
				held.center_coord = x_sum >> 1;
				held.target_width = w_sum;
			end
			seen = '0;
			expected_targets.push_back(held);
		endfunction

		function void check_result(result_t r);
			result_t exp_r;
			result_count++;
			if (expected_targets.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual center %0d width %0d",
					$time, r.center_coord, r.target_width);
				mismatches++;
				return;
			end
			exp_r = expected_targets.pop_front();
			if (r.center_coord !== exp_r.center_coord) begin
				$display("%0t: center_coord expected %0d actual %0d",
					$time, exp_r.center_coord, r.center_coord);
				mismatches++;
			end
			if (r.target_width !== exp_r.target_width) begin
				$display("%0t: target_width expected %0d actual %0d",
					$time, exp_r.target_width, r.target_width);
				mismatches++;
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [SIG_W-1:0] cfg_data;
	logic             blob_valid;
	logic             blob_ready;
	blob_t            blob_in;
	logic             result_valid;
	result_t          result;
	logic             result_ready;

	target_scoreboard sb = new();

	bit gaps_enabled = 1'b1;
	int hold_req = 0;
	int longest_hold = 0;
	int drains = 0;
	int settings_used = 1;
	logic [COORD_W-1:0] prev_w = '0;
	logic [COORD_W-1:0] prev_h = '0;

	top_two_blob_target_combiner dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.blob_valid(blob_valid),
		.blob_ready(blob_ready),
		.blob(blob_in),
		.result_valid(result_valid),
		.result(result),
		.result_ready(result_ready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	function automatic logic [COORD_W-1:0] rand_coord();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return COORD_W'($urandom_range(0, 511));
	endfunction

	function automatic blob_t blob_of(int x, int w, int h, int sig, bit last, bit empty);
		blob_t b;
		b.block_x = COORD_W'(x);
		b.block_width = COORD_W'(w);
		b.block_height = COORD_W'(h);
		b.block_signature = SIG_W'(sig);
		b.last_in_frame = last;
		b.empty_frame = empty;
		return b;
	endfunction

	function automatic blob_t random_blob();
		blob_t b;
		b.block_x = rand_coord();
		// Reusing the previous dimensions now and then produces equal areas.
		if ($urandom_range(0, 9) == 0) begin
			b.block_width = prev_w;
			b.block_height = prev_h;
		end else begin
			b.block_width = rand_coord();
			b.block_height = rand_coord();
		end
		prev_w = b.block_width;
		prev_h = b.block_height;
		b.block_signature = SIG_W'($urandom_range(0, 7));
		b.last_in_frame = ($urandom_range(0, 1) == 1);
		b.empty_frame = 1'b0;
		return b;
	endfunction

	// Valid stays high across back-to-back transactions; this task drops it only for a gap.
	task automatic send_blob(blob_t b);
		int gap;
		gap = gaps_enabled ? pick_gap() : 0;
		if (gap > 0) begin
			blob_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		blob_valid <= 1'b1;
		blob_in <= b;
		do @(posedge clk); while (!blob_ready);
		sb.note_blob(b);
	endtask

	task automatic settle();
		blob_valid <= 1'b0;
		while (sb.expected_targets.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		drains++;
	endtask

	task automatic write_target(logic [SIG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.target = value;
		settings_used++;
	endtask

	task automatic send_frame();
		int n;
		blob_t b;
		n = ($urandom_range(0, 9) < 3) ? 1 : $urandom_range(2, 8);
		if ($urandom_range(0, 99) < 6) begin
			b = random_blob();
			b.empty_frame = 1'b1;
			send_blob(b);
			return;
		end
		for (int i = 0; i < n; i++) begin
			b = random_blob();
			// A stray empty frame in the middle cuts the frame short.
			if ($urandom_range(0, 99) < 3) begin
				b.empty_frame = 1'b1;
				send_blob(b);
				return;
			end
			if (i >= 2 && $urandom_range(0, 99) < 60)
				b.block_signature = sb.target;
			b.last_in_frame = (i == n - 1);
			send_blob(b);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sb.check_result(result);
	end

	initial begin
		int left;
		bit level;
		int r;
		left = 0;
		level = 1'b0;
		result_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				left = hold_req;
				if (hold_req > longest_hold)
					longest_hold = hold_req;
				hold_req = 0;
				level = 1'b0;
			end else if (left <= 0) begin
				r = $urandom_range(0, 99);
				if (r < 10) begin
					level = 1'b1;
					left = $urandom_range(50, 150);
				end else begin
					level = ($urandom_range(0, 99) < 60);
					if (r < 75)
						left = $urandom_range(1, 3);
					else if (r < 95)
						left = $urandom_range(4, 10);
					else
						left = $urandom_range(20, 60);
				end
			end
			result_ready <= level;
			left--;
		end
	end

	initial begin
		int start;
		logic [SIG_W-1:0] settings[5];
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		blob_valid = 1'b0;
		blob_in = '0;
		settings[0] = 3'd7;
		settings[1] = 3'd0;
		settings[2] = SIG_W'($urandom_range(1, 7));
		settings[3] = SIG_W'($urandom_range(1, 7));
		settings[4] = 3'd1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames under the reset target signature.
		send_blob(blob_of(0, 0, 0, 0, 1'b0, 1'b1));
		send_blob(blob_of(511, 511, 511, 7, 1'b1, 1'b0));
		send_blob(blob_of(511, 511, 511, 7, 1'b1, 1'b1));
		send_blob(blob_of(0, 0, 0, 0, 1'b0, 1'b0));
		send_blob(blob_of(511, 511, 511, 7, 1'b1, 1'b0));
		send_blob(blob_of(10, 4, 4, 5, 1'b0, 1'b0));
		send_blob(blob_of(20, 8, 2, 6, 1'b1, 1'b0));
		send_blob(blob_of(100, 10, 10, 3, 1'b0, 1'b0));
		send_blob(blob_of(200, 5, 5, 3, 1'b0, 1'b0));
		send_blob(blob_of(300, 20, 20, 1, 1'b0, 1'b0));
		send_blob(blob_of(400, 511, 511, 2, 1'b0, 1'b0));
		send_blob(blob_of(50, 12, 12, 1, 1'b0, 1'b0));
		send_blob(blob_of(60, 12, 12, 1, 1'b1, 1'b0));
		send_blob(blob_of(5, 3, 3, 1, 1'b0, 1'b0));
		send_blob(blob_of(6, 3, 3, 1, 1'b0, 1'b0));
		send_blob(blob_of(0, 0, 0, 0, 1'b0, 1'b1));
		send_blob(blob_of(0, 511, 1, 4, 1'b0, 1'b0));
		send_blob(blob_of(511, 511, 1, 4, 1'b1, 1'b0));
		settle();

		// With a target of zero, later blobs of signature zero take part.
		write_target(3'd0);
		send_blob(blob_of(30, 2, 2, 1, 1'b0, 1'b0));
		send_blob(blob_of(40, 3, 3, 1, 1'b0, 1'b0));
		send_blob(blob_of(90, 9, 9, 0, 1'b1, 1'b0));
		settle();
		write_target(TARGET_RESET);

		// Receiver holds off while single-blob frames arrive back to back.
		hold_req = LONG_HOLD;
		gaps_enabled = 1'b0;
		repeat (BURST_FRAMES) begin
			blob_in_frame_end: begin
				blob_t b;
				b = random_blob();
				b.last_in_frame = 1'b1;
				send_blob(b);
			end
		end
		gaps_enabled = 1'b1;
		settle();

		foreach (settings[p]) begin
			write_target(settings[p]);
			start = sb.blob_count;
			while (sb.blob_count - start < PHASE_ITEMS) begin
				if ($urandom_range(0, 49) == 0)
					gaps_enabled = ($urandom_range(0, 3) != 0);
				send_frame();
			end
			gaps_enabled = 1'b1;
			settle();
		end

		$display("Run covered %0d blobs, %0d results over %0d target settings.",
			sb.blob_count, sb.result_count, settings_used);
		$display("Longest receiver hold-off %0d cycles; block drained %0d times.",
			longest_hold, drains);
		if (sb.mismatches == 0 && sb.expected_targets.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Timed out with %0d results outstanding", sb.expected_targets.size());
		$display("Mismatches found");
		$finish;
	end

endmodule
